// ----- rtl/dect_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dect_pkg
// Shared widths, register map and helpers for the drop event counter table.
// ----------------------------------------------------------------------------
package dect_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int ERR_W   = 16;
    localparam int EVT_W   = 31;
    localparam int COUNT_W = 32;
    localparam int TS_W    = 63;
    localparam int UID_W   = 32;
    localparam int END_W   = 64;

    // stream payloads, padded to whole bytes
    localparam int IN_DATA_W  = 112;
    localparam int OUT_USED_W = ERR_W + EVT_W + 2 * COUNT_W + 2 * TS_W + UID_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_SELF_ID  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_UID      = 2'd2;

    localparam logic [COUNT_W-1:0] COOLDOWN_RST = 32'd10000;

    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [EVT_W-1:0]   evt;
        logic [COUNT_W-1:0] count;
    } slot_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ----- rtl/drop_event_counter_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drop_event_counter_table
// Table of distinct (error, event id) drop pairs with saturating counts,
// an overflow counter, first/last drop times and a cooldown-gated dump.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+------------------------------
//  s_*       | in  | s_tvalid / s_tready        | s_tdata drop or dump request,
//            |     |                            | s_tuser func
//  m_*       | out | m_tvalid / m_tready        | m_tdata table entry + header,
//            |     |                            | m_tlast end of dump
//  apb       | in  | psel / penable, pready = 1 | three config registers
//
//  a drop of the own event id ends at the accept; any other drop is accepted,
//  then searches each occupied slot in turn (one shared compare on the
//  registered table read port) and inserts the pair when it is new.
//  a dump is accepted and then gives one beat per occupied slot, one a
//  cycle while m_tready is high; the output register stalls the walk.
//  s_tready is high only while the sequencer is idle.
//  reset empties the table at once through the fill count: no clearing pass.
// ----------------------------------------------------------------------------
module drop_event_counter_table #(
    parameter int TABLE_DEPTH = dect_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // error_code[15:0], event_id[46:16], now_ns[109:47], force_req[110],
    // write_ok[111]
    input  logic [dect_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_error[15:0], out_event_id[46:16], drop_count[78:47],
    // overflow_count[110:79], first_ts[173:111], last_ts[236:174],
    // uid[268:237], zero pad above
    output logic [dect_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dect_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dect_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dect_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import dect_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_DUMP   = 2'd3;

    // control state
    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [COUNT_W-1:0] overflow_reg, overflow_next;
    logic [TS_W-1:0]    first_ts_reg, first_ts_next;
    logic [TS_W-1:0]    last_ts_reg, last_ts_next;
    logic [END_W-1:0]   cool_end_reg, cool_end_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [EVT_W-1:0]   self_id_reg;
    logic [COUNT_W-1:0] cooldown_reg;
    logic [UID_W-1:0]   uid_reg;

    // payload
    logic [ERR_W-1:0]      err_reg, err_next;
    logic [EVT_W-1:0]      evt_reg, evt_next;
    logic [TS_W-1:0]       now_reg, now_next;
    logic                  clr_reg, clr_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    // table memory
    slot_t              mem [TABLE_DEPTH];
    slot_t              rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_t              wr_data;

    // input fields
    logic [ERR_W-1:0] in_err;
    logic [EVT_W-1:0] in_evt;
    logic [TS_W-1:0]  in_now;
    logic             in_force;
    logic             in_ok;
    logic             accept;
    logic             hit;
    logic             last_slot;
    logic             full;
    logic             out_free;
    logic             cfg_wr;

    assign in_err   = s_tdata[15:0];
    assign in_evt   = s_tdata[46:16];
    assign in_now   = s_tdata[109:47];
    assign in_force = s_tdata[110];
    assign in_ok    = s_tdata[111];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign hit       = (rd_data_reg.err == err_reg) && (rd_data_reg.evt == evt_reg);
    assign last_slot = (USED_W'(idx_reg) + USED_W'(1)) == used_reg;
    assign full      = (used_reg == USED_W'(TABLE_DEPTH));
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_SELF_ID:  prdata = APB_DATA_W'(self_id_reg);
            REG_COOLDOWN: prdata = cooldown_reg;
            REG_UID:      prdata = uid_reg;
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        used_next     = used_reg;
        overflow_next = overflow_reg;
        first_ts_next = first_ts_reg;
        last_ts_next  = last_ts_reg;
        cool_end_next = cool_end_reg;
        m_tvalid_next = m_tvalid_reg;
        err_next      = err_reg;
        evt_next      = evt_reg;
        now_next      = now_reg;
        clr_next      = clr_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = '{err: err_reg, evt: evt_reg, count: COUNT_W'(1)};

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = '0;
                if (accept)
                begin
                    err_next = in_err;
                    evt_next = in_evt;
                    now_next = in_now;
                    clr_next = in_ok;
                    idx_next = '0;
                    if (!s_tuser)
                    begin
                        // a zero first time stays open for the next drop
                        if (first_ts_reg == '0)
                        begin
                            first_ts_next = in_now;
                        end
                        last_ts_next = in_now;
                        if (in_evt != self_id_reg)
                        begin
                            state_next = (used_reg == '0) ? ST_INSERT : ST_SCAN;
                        end
                    end
                    else if ((in_force || !(cool_end_reg > {1'b0, in_now}))
                             && (used_reg != '0))
                    begin
                        state_next = ST_DUMP;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_addr = idx_reg + IDX_W'(1);
                if (hit)
                begin
                    wr_en         = 1'b1;
                    wr_data.count = sat_inc(rd_data_reg.count);
                    state_next    = ST_IDLE;
                end
                else if (last_slot)
                begin
                    if (full)
                    begin
                        overflow_next = sat_inc(overflow_reg);
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_INSERT:
            begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(used_reg);
                used_next  = used_reg + USED_W'(1);
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = last_slot;
                    m_tdata_next  = {OUT_PAD_W'(0), uid_reg, last_ts_reg, first_ts_reg,
                                     overflow_reg, rd_data_reg.count, rd_data_reg.evt,
                                     rd_data_reg.err};
                    if (last_slot)
                    begin
                        state_next    = ST_IDLE;
                        cool_end_next = {1'b0, now_reg} + END_W'(cooldown_reg);
                        if (clr_reg)
                        begin
                            used_next     = '0;
                            overflow_next = '0;
                            first_ts_next = '0;
                            last_ts_next  = '0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            used_reg     <= '0;
            overflow_reg <= '0;
            first_ts_reg <= '0;
            last_ts_reg  <= '0;
            cool_end_reg <= '0;
            m_tvalid_reg <= 1'b0;
            self_id_reg  <= '0;
            cooldown_reg <= COOLDOWN_RST;
            uid_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            used_reg     <= used_next;
            overflow_reg <= overflow_next;
            first_ts_reg <= first_ts_next;
            last_ts_reg  <= last_ts_next;
            cool_end_reg <= cool_end_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_SELF_ID:  self_id_reg  <= pwdata[EVT_W-1:0];
                    REG_COOLDOWN: cooldown_reg <= pwdata;
                    REG_UID:      uid_reg      <= pwdata;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        evt_reg     <= evt_next;
        now_reg     <= now_next;
        clr_reg     <= clr_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // single write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ----- rtl/dect_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dect_checker
// Port-level checks for the drop event counter table, bound to the top level.
// ----------------------------------------------------------------------------
module dect_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dect_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import dect_pkg::*;

    localparam int CNT_LO = ERR_W + EVT_W;

    // a stalled beat stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // a stalled beat keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // every table entry has been counted at least once
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[CNT_LO +: COUNT_W] != '0))
        else $error("result beat with zero drop count");

    // a dump still running keeps the input side closed
    a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a dump");

endmodule

bind drop_event_counter_table dect_checker u_dect_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
